/* design/rgbe_pkg.sv */
// Shared types and constants for the RGBE scanline decoder.
// No dependencies.
package rgbe_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PIXEL     = 3'd1;
  localparam logic [2:0] ST_WAIT      = 3'd2;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int COL_W  = 13;
  localparam int LINE_W = 15;

  typedef struct packed {
    logic       en;
    logic [1:0] plane;
    logic [12:0] col;
  } store_acc_t;

endpackage

/* design/rgbe_scanline_rle_decoder_top.sv */
// Top level of the RGBE scanline decoder: sequencer, state and output register.
// Depends on rgbe_pkg, rgbe_line_store and rgbe_f32_conv.
//
// Each transaction on the input channel is a push of one stream byte (tuser 0)
// or a pull of one decoded pixel (tuser 1), and yields exactly one result
// transaction. A literal byte or a repeat run is written to the line store one
// byte at a time. A pull from a flat pixel makes three passes through the
// shared float converter; a pull from a run-length line first makes four reads
// through the single registered line store port, then the three passes. The
// input is not ready again until the result transaction has been taken. The
// line store needs no clearing after reset.
module rgbe_scanline_rle_decoder_top import rgbe_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // status, red_bits, green_bits, blue_bits, zero fill
  output logic         out_tlast,  // line_end
  output logic         out_tuser,  // frame_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [14:0]  cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FILL, S_READ, S_CONV} seq_t;
  typedef enum logic [2:0] {PH_START, PH_COUNT, PH_DATA, PH_LINE, PH_PIXEL} phase_t;

  seq_t        seq_r, seq_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [12:0] col_r, col_nxt;
  logic [7:0]  run_r, run_nxt;
  logic        rep_r, rep_nxt;
  logic [14:0] lines_r, lines_nxt;
  logic [31:0] pbytes_r, pbytes_nxt;
  logic [12:0] drain_r, drain_nxt;
  logic        flat_r, flat_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [12:0] width_r, width_nxt;
  logic [14:0] height_r, height_nxt;
  logic        act_r, act_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic        le_r, le_nxt;
  logic        fe_r, fe_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [31:0] ored_r, ored_nxt;
  logic [31:0] ogrn_r, ogrn_nxt;
  logic [31:0] oblu_r, oblu_nxt;
  logic        ole_r, ole_nxt;
  logic        ofe_r, ofe_nxt;

  logic [12:0] w;
  logic [14:0] h;
  store_acc_t  wr, rd;
  logic [7:0]  rd_data;
  logic [7:0]  cv_mant;
  logic [31:0] cv_bits;

  rgbe_line_store #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_store (
    .clk(clk), .wr(wr), .wr_data(byte_r), .rd(rd), .rd_data(rd_data)
  );

  rgbe_f32_conv u_conv (.mant(cv_mant), .expo(pix_r[31:24]), .bits(cv_bits));

  assign w = (width_r == 13'd0) ? 13'd1 : width_r;
  assign h = (height_r == 15'd0) ? 15'd1 : height_r;

  assign in_tready  = (seq_r == S_IDLE) && !ov_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, oblu_r, ogrn_r, ored_r, ost_r};
  assign out_tlast  = ole_r;
  assign out_tuser  = ofe_r;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    cv_mant = pix_r[7:0];
      2'd1:    cv_mant = pix_r[15:8];
      default: cv_mant = pix_r[23:16];
    endcase
  end

  always_comb begin
    logic [13:0] pos1;
    logic [13:0] room;
    logic [7:0]  n;
    logic        finish;
    logic [12:0] col_inc;
    logic [7:0]  run_dec;
    logic        line_done;

    seq_nxt = seq_r;     phase_nxt = phase_r;   plane_nxt = plane_r;
    col_nxt = col_r;     run_nxt = run_r;       rep_nxt = rep_r;
    lines_nxt = lines_r; pbytes_nxt = pbytes_r; drain_nxt = drain_r;
    flat_nxt = flat_r;   err_nxt = err_r;       width_nxt = width_r;
    height_nxt = height_r; act_nxt = act_r;     byte_nxt = byte_r;
    cnt_nxt = cnt_r;     pix_nxt = pix_r;       le_nxt = le_r;
    fe_nxt = fe_r;       ov_nxt = ov_r;         ost_nxt = ost_r;
    ored_nxt = ored_r;   ogrn_nxt = ogrn_r;     oblu_nxt = oblu_r;
    ole_nxt = ole_r;     ofe_nxt = ofe_r;
    wr = '0;
    rd = '0;
    pos1 = 14'd0;
    room = 14'd0;
    n = 8'd0;
    finish = 1'b0;
    col_inc = col_r + 13'd1;
    run_dec = run_r - 8'd1;
    line_done = 1'b0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_nxt = cfg_data[12:0];
        CFG_HEIGHT: height_nxt = cfg_data;
        default:    ;
      endcase
    end

    unique case (seq_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          act_nxt  = in_tuser;
          byte_nxt = in_tdata;
          seq_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        ost_nxt = ST_OK;
        finish  = 1'b1;
        if (err_r != ST_OK) begin
          ost_nxt = err_r;
        end else if (act_r) begin
          if (phase_r == PH_PIXEL) begin
            pos1   = 14'(col_r) + 14'd1;
            le_nxt = pos1 >= 14'(w);
            fe_nxt = le_nxt && (16'(lines_r) + 16'd1 >= 16'(h));
            pix_nxt = pbytes_r;
            col_nxt = col_inc;
            phase_nxt = PH_START;
            plane_nxt = 2'd0;
            line_done = le_nxt;
            finish  = 1'b0;
            cnt_nxt = 3'd0;
            seq_nxt = S_CONV;
          end else if (phase_r == PH_LINE) begin
            pos1   = 14'(drain_r) + 14'd1;
            le_nxt = pos1 >= 14'(w);
            fe_nxt = le_nxt && (16'(lines_r) + 16'd1 >= 16'(h));
            finish  = 1'b0;
            cnt_nxt = 3'd0;
            seq_nxt = S_READ;
          end else begin
            ost_nxt = ST_WAIT;
          end
        end else begin
          unique case (phase_r)
            PH_START: begin
              unique case (plane_r)
                2'd0: pbytes_nxt = {24'd0, byte_r};
                2'd1: pbytes_nxt[15:8] = byte_r;
                2'd2: pbytes_nxt[23:16] = byte_r;
                default: pbytes_nxt[31:24] = byte_r;
              endcase
              if (plane_r != 2'd3) begin
                plane_nxt = plane_r + 2'd1;
              end else begin
                plane_nxt = 2'd0;
                if (flat_r || w < 13'd8 || pbytes_r[7:0] != 8'd2 ||
                    pbytes_r[15:8] != 8'd2 || pbytes_r[23]) begin
                  flat_nxt  = 1'b1;
                  phase_nxt = PH_PIXEL;
                end else if ({pbytes_r[23:16], byte_r} != 16'(w) ||
                             16'(w) > 16'(MAX_LINE_WIDTH)) begin
                  err_nxt = ST_BAD_WIDTH;
                  ost_nxt = ST_BAD_WIDTH;
                end else begin
                  col_nxt   = 13'd0;
                  phase_nxt = PH_COUNT;
                end
              end
            end
            PH_COUNT: begin
              room = (col_r < w) ? 14'(w) - 14'(col_r) : 14'd0;
              n    = (byte_r > 8'd128) ? byte_r - 8'd128 : byte_r;
              if (n == 8'd0 || 14'(n) > room) begin
                err_nxt = ST_BAD_COUNT;
                ost_nxt = ST_BAD_COUNT;
              end else begin
                run_nxt   = n;
                rep_nxt   = byte_r > 8'd128;
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              finish  = 1'b0;
              seq_nxt = S_FILL;
            end
            default: ost_nxt = ST_WAIT;
          endcase
        end
      end

      S_FILL: begin
        wr.en    = 1'b1;
        wr.plane = plane_r;
        wr.col   = col_r;
        col_nxt  = col_inc;
        run_nxt  = run_dec;
        if (!(rep_r && run_dec != 8'd0)) begin
          ost_nxt = ST_OK;
          finish  = 1'b1;
          if (run_dec == 8'd0) begin
            if (col_inc >= w) begin
              col_nxt = 13'd0;
              if (plane_r == 2'd3) begin
                plane_nxt = 2'd0;
                drain_nxt = 13'd0;
                phase_nxt = PH_LINE;
              end else begin
                plane_nxt = plane_r + 2'd1;
                phase_nxt = PH_COUNT;
              end
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
        end
      end

      S_READ: begin
        rd.en    = cnt_r != 3'd4;
        rd.plane = cnt_r[1:0];
        rd.col   = drain_r;
        unique case (cnt_r)
          3'd1: pix_nxt[7:0] = rd_data;
          3'd2: pix_nxt[15:8] = rd_data;
          3'd3: pix_nxt[23:16] = rd_data;
          3'd4: pix_nxt[31:24] = rd_data;
          default: ;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          cnt_nxt = 3'd0;
          if (le_r) begin
            drain_nxt = 13'd0;
            line_done = 1'b1;
          end else begin
            drain_nxt = drain_r + 13'd1;
          end
          seq_nxt = S_CONV;
        end
      end

      S_CONV: begin
        unique case (cnt_r[1:0])
          2'd0:    ored_nxt = cv_bits;
          2'd1:    ogrn_nxt = cv_bits;
          default: oblu_nxt = cv_bits;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          ov_nxt  = 1'b1;
          ost_nxt = ST_PIXEL;
          ole_nxt = le_r;
          ofe_nxt = fe_r;
          seq_nxt = S_IDLE;
        end
      end

      default: seq_nxt = S_IDLE;
    endcase

    if (line_done) begin
      col_nxt   = 13'd0;
      plane_nxt = 2'd0;
      phase_nxt = PH_START;
      if (16'(lines_r) + 16'd1 >= 16'(h)) begin
        lines_nxt = 15'd0;
        flat_nxt  = 1'b0;
      end else begin
        lines_nxt = lines_r + 15'd1;
      end
    end

    if (finish) begin
      ov_nxt   = 1'b1;
      ored_nxt = 32'd0;
      ogrn_nxt = 32'd0;
      oblu_nxt = 32'd0;
      ole_nxt  = 1'b0;
      ofe_nxt  = 1'b0;
      seq_nxt  = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= S_IDLE;
      phase_r  <= PH_START;
      plane_r  <= 2'd0;
      col_r    <= 13'd0;
      run_r    <= 8'd0;
      rep_r    <= 1'b0;
      lines_r  <= 15'd0;
      pbytes_r <= 32'd0;
      drain_r  <= 13'd0;
      flat_r   <= 1'b0;
      err_r    <= ST_OK;
      width_r  <= 13'd1;
      height_r <= 15'd1;
      cnt_r    <= 3'd0;
      ov_r     <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      phase_r  <= phase_nxt;
      plane_r  <= plane_nxt;
      col_r    <= col_nxt;
      run_r    <= run_nxt;
      rep_r    <= rep_nxt;
      lines_r  <= lines_nxt;
      pbytes_r <= pbytes_nxt;
      drain_r  <= drain_nxt;
      flat_r   <= flat_nxt;
      err_r    <= err_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
    act_r  <= act_nxt;
    byte_r <= byte_nxt;
    pix_r  <= pix_nxt;
    le_r   <= le_nxt;
    fe_r   <= fe_nxt;
    ost_r  <= ost_nxt;
    ored_r <= ored_nxt;
    ogrn_r <= ogrn_nxt;
    oblu_r <= oblu_nxt;
    ole_r  <= ole_nxt;
    ofe_r  <= ofe_nxt;
  end

endmodule

/* design/rgbe_line_store.sv */
// Four-plane scanline byte store, one write and one registered read port.
// Depends on rgbe_pkg.
module rgbe_line_store import rgbe_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  logic       clk,
  input  store_acc_t wr,
  input  logic [7:0] wr_data,
  input  store_acc_t rd,
  output logic [7:0] rd_data
);

  localparam int Depth = 4 * MAX_LINE_WIDTH;
  localparam int AW    = $clog2(Depth);

  logic [7:0]    mem [Depth];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_in_range;
  logic          rd_in_range;
  logic          rd_in_range_r;
  logic [7:0]    rd_raw_r;

  function automatic logic [AW-1:0] addr_of(input logic [1:0] plane,
                                            input logic [12:0] col);
    logic [17:0] base;
    logic [17:0] sum;
    base = 18'(plane) * 18'(MAX_LINE_WIDTH);
    sum  = base + 18'(col);
    return sum[AW-1:0];
  endfunction

  assign wr_addr     = addr_of(wr.plane, wr.col);
  assign rd_addr     = addr_of(rd.plane, rd.col);
  assign wr_in_range = 16'(wr.col) < 16'(MAX_LINE_WIDTH);
  assign rd_in_range = 16'(rd.col) < 16'(MAX_LINE_WIDTH);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd.en) begin
      rd_raw_r      <= mem[rd_addr];
      rd_in_range_r <= rd_in_range;
    end
  end

  assign rd_data = rd_in_range_r ? rd_raw_r : 8'd0;

endmodule

/* design/rgbe_f32_conv.sv */
// Converts one RGBE mantissa byte and shared exponent to an IEEE single.
// Depends on rgbe_pkg.
module rgbe_f32_conv import rgbe_pkg::*; (
  input  logic [7:0]  mant,
  input  logic [7:0]  expo,
  output logic [31:0] bits
);

  logic [2:0]  msb;
  logic [8:0]  ex;
  logic [8:0]  ex_adj;
  logic [31:0] frac;
  logic [31:0] denorm;

  always_comb begin
    msb = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if ((mant >> i) != 8'd0) begin
        msb = 3'(i);
      end
    end
    ex     = 9'(expo) + 9'(msb);
    ex_adj = ex - 9'd9;
    frac   = (32'(mant) << (5'd23 - 5'(msb))) & 32'h007f_ffff;
    denorm = 32'(mant) << (6'(expo[3:0]) + 6'd13);
    if (expo == 8'd0 || mant == 8'd0) begin
      bits = 32'd0;
    end else if (ex >= 9'd10) begin
      bits = {1'b0, ex_adj[7:0], frac[22:0]};
    end else begin
      bits = denorm;
    end
  end

endmodule

/* tb/rgbe_scanline_rle_decoder_top_test.sv */
// Testbench for the RGBE scanline decoder: directed, extreme size, random, backpressure and error tests.
// Predicts each result with its own model of the decoder and checks every result transaction.
// Depends on rgbe_pkg and rgbe_scanline_rle_decoder_top.
module rgbe_scanline_rle_decoder_top_test;
  import rgbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 4096;
  localparam int IDLE_LIMIT = 5000;

  typedef enum logic [2:0] {
    PH_START, PH_COUNT, PH_DATA, PH_LINE, PH_PIXEL
  } phase_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        line_end;
    logic        frame_end;
  } pixel_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [14:0]  cfg_data;

  rgbe_scanline_rle_decoder_top u_top (.*);

  // Predicted decoder state.
  logic [7:0]  line_mem [0:4*MAX_W-1];
  phase_t      phase;
  logic [1:0]  plane;
  logic [12:0] col;
  logic [7:0]  run_cnt;
  logic        run_rep;
  logic [14:0] lines;
  logic [31:0] pix;
  logic [12:0] drain;
  logic        flat;
  logic [2:0]  err;
  logic [12:0] reg_width;
  logic [14:0] reg_height;

  pixel_result_t pending_q[$];
  int unsigned n_fail, n_push, n_pull, n_pixels, n_lines_rle, n_errs;
  int unsigned burst_left, hold_req, idle_cycles;
  bit gaps_on, stalls_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rgbe_to_f32(logic [7:0] m, logic [7:0] e);
    int unsigned p, ex;
    if (e == 0 || m == 0) return 32'd0;
    p = 0;
    while (p < 7 && (m >> (p + 1)) != 0) p++;
    ex = p + e;
    if (ex >= 10) return ((ex - 9) << 23) | ((32'(m) << (23 - p)) & 32'h7fffff);
    return 32'(m) << (e + 13);
  endfunction

  function automatic void line_done(int unsigned h);
    lines++;
    col = '0;
    plane = '0;
    phase = PH_START;
    if (lines >= h) begin
      lines = '0;
      flat = 1'b0;
    end
  endfunction

  function automatic pixel_result_t decode_step(logic pull, logic [7:0] dbyte);
    pixel_result_t res;
    int unsigned w, h, room, n, a;
    logic [7:0] r, g, b, e;
    res = '{default: '0};
    w = (reg_width == 0) ? 1 : reg_width;
    h = (reg_height == 0) ? 1 : reg_height;
    if (err != ST_OK) begin
      res.status = err;
      return res;
    end
    if (pull) begin
      if (phase == PH_PIXEL) begin
        {e, b, g, r} = pix;
        res.line_end = (col + 1 >= w);
        res.frame_end = res.line_end && (lines + 1 >= h);
        col++;
        phase = PH_START;
        plane = '0;
        if (col >= w) line_done(h);
      end else if (phase == PH_LINE) begin
        r = (drain < MAX_W) ? line_mem[drain] : 8'd0;
        g = (drain < MAX_W) ? line_mem[MAX_W + drain] : 8'd0;
        b = (drain < MAX_W) ? line_mem[2*MAX_W + drain] : 8'd0;
        e = (drain < MAX_W) ? line_mem[3*MAX_W + drain] : 8'd0;
        res.line_end = (drain + 1 >= w);
        res.frame_end = res.line_end && (lines + 1 >= h);
        drain++;
        if (drain >= w) begin
          drain = '0;
          line_done(h);
        end
      end else begin
        res.status = ST_WAIT;
        return res;
      end
      res.status = ST_PIXEL;
      res.red = rgbe_to_f32(r, e);
      res.green = rgbe_to_f32(g, e);
      res.blue = rgbe_to_f32(b, e);
      return res;
    end
    case (phase)
      PH_START: begin
        if (plane == 0) pix = '0;
        pix[8*plane +: 8] = dbyte;
        if (plane < 3) begin
          plane++;
        end else begin
          plane = '0;
          if (flat || w < 8 || pix[7:0] != 2 || pix[15:8] != 2 || pix[23]) begin
            flat = 1'b1;
            phase = PH_PIXEL;
          end else if ({pix[23:16], pix[31:24]} != w || w > MAX_W) begin
            err = ST_BAD_WIDTH;
          end else begin
            col = '0;
            phase = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        room = (col < w) ? w - col : 0;
        n = (dbyte > 128) ? dbyte - 128 : dbyte;
        if (n == 0 || n > room) begin
          err = ST_BAD_COUNT;
        end else begin
          run_cnt = 8'(n);
          run_rep = (dbyte > 128);
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        a = run_rep ? run_cnt : 1;
        repeat (a) begin
          if (col < MAX_W) line_mem[plane*MAX_W + col] = dbyte;
          col++;
          run_cnt--;
        end
        if (run_cnt == 0) begin
          if (col >= w) begin
            col = '0;
            if (plane >= 3) begin
              plane = '0;
              drain = '0;
              phase = PH_LINE;
            end else begin
              plane++;
              phase = PH_COUNT;
            end
          end else begin
            phase = PH_COUNT;
          end
        end
      end
      default: res.status = ST_WAIT;
    endcase
    res.status = (err != ST_OK) ? err : res.status;
    return res;
  endfunction

  // Sends one item in bursts, with random gaps between bursts while gaps_on is set, and records its predicted result.
  task automatic send_item(logic pull, logic [7:0] dbyte);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= pull;
    in_tdata <= dbyte;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(decode_step(pull, dbyte));
    if (pull) n_pull++;
    else n_push++;
  endtask

  task automatic push_byte(logic [7:0] dbyte);
    if ($urandom_range(0, 39) == 0) send_item(1'b1, 8'($urandom));
    send_item(1'b0, dbyte);
  endtask

  task automatic pull_pixel();
    if ($urandom_range(0, 39) == 0) send_item(1'b0, 8'($urandom));
    send_item(1'b1, 8'($urandom));
    n_pixels++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) reg_width = val[12:0];
    else reg_height = val;
  endtask

  task automatic flat_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] e);
    push_byte(r);
    push_byte(g);
    push_byte(b);
    push_byte(e);
    pull_pixel();
  endtask

  // One run-length scanline; wide selects the longest runs and literals.
  task automatic rle_line(int unsigned w, bit wide);
    int unsigned c, n, room;
    push_byte(8'd2);
    push_byte(8'd2);
    push_byte(8'(w >> 8));
    push_byte(8'(w & 8'hff));
    for (int p = 0; p < 4; p++) begin
      c = 0;
      while (c < w) begin
        room = w - c;
        if ($urandom_range(0, 1)) begin
          n = wide ? ((room < 127) ? room : 127) : $urandom_range(1, (room < 12) ? room : 12);
          push_byte(8'(128 + n));
          push_byte(8'($urandom));
        end else begin
          n = wide ? ((room < 128) ? room : 128) : $urandom_range(1, (room < 12) ? room : 12);
          push_byte(8'(n));
          repeat (n) push_byte(8'($urandom));
        end
        c += n;
      end
    end
    n_lines_rle++;
    repeat (w) pull_pixel();
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, bit rle, bit wide);
    logic [7:0] b0;
    for (int unsigned l = 0; l < h; l++) begin
      if (rle && w >= 8) begin
        rle_line(w, wide);
      end else begin
        for (int unsigned c = 0; c < w; c++) begin
          b0 = 8'($urandom);
          if (l == 0 && c == 0 && b0 == 8'd2) b0 = 8'd3;
          flat_pixel(b0, 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_directed();
    send_item(1'b1, 8'h00);
    flat_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    flat_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    flat_pixel(8'h01, 8'h80, 8'h7f, 8'h01);
    flat_pixel(8'h55, 8'haa, 8'h01, 8'h00);
    push_byte(8'h02);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'h08);
    send_item(1'b0, 8'h5a);
    send_item(1'b1, 8'h00);
    write_reg(CFG_WIDTH, 15'd0);
    write_reg(CFG_HEIGHT, 15'd0);
    flat_pixel(8'h02, 8'h02, 8'h00, 8'h01);
    write_reg(CFG_WIDTH, 15'd140);
    write_reg(CFG_HEIGHT, 15'd2);
    run_frame(140, 2, 1'b1, 1'b1);
    write_reg(CFG_WIDTH, 15'd8);
    run_frame(8, 2, 1'b0, 1'b0);
  endtask

  task automatic test_random_frames(int unsigned items);
    int unsigned w, h;
    while (n_push + n_pull < items) begin
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 40);
      h = $urandom_range(1, 3);
      write_reg(CFG_WIDTH, 15'(w));
      write_reg(CFG_HEIGHT, 15'(h));
      run_frame(w, h, $urandom_range(0, 4) != 0, 1'b0);
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WIDTH, 15'd16);
    write_reg(CFG_HEIGHT, 15'd2);
    hold_req = 600;
    gaps_on = 1'b0;
    run_frame(16, 2, 1'b1, 1'b0);
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_extreme_sizes();
    write_reg(CFG_WIDTH, 15'd8);
    write_reg(CFG_HEIGHT, 15'd1);
    run_frame(8, 1, 1'b1, 1'b1);
    write_reg(CFG_WIDTH, 15'd9);
    write_reg(CFG_HEIGHT, 15'd32767);
    run_frame(9, 2, 1'b1, 1'b0);
    write_reg(CFG_HEIGHT, 15'd1);
    run_frame(9, 1, 1'b1, 1'b0);
  endtask

  task automatic test_sticky_error();
    int unsigned pick;
    pick = $urandom_range(0, 4);
    write_reg(CFG_WIDTH, (pick == 4) ? 15'd8191 : 15'd12);
    write_reg(CFG_HEIGHT, 15'd1);
    push_byte(8'd2);
    push_byte(8'd2);
    if (pick == 4) begin
      push_byte(8'h1f);
      push_byte(8'hff);
    end else begin
      push_byte(8'd0);
      push_byte((pick == 0) ? 8'd13 : 8'd12);
      case (pick)
        1: push_byte(8'd0);
        2: push_byte(8'd128);
        3: push_byte(8'd141);
        default: ;
      endcase
    end
    repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    n_errs++;
  endtask

  // Receiver stalls on a counter pattern, or holds off for a counted stretch.
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req > 0) begin
        out_tready <= 1'b0;
        hold_req--;
      end else if (stalls_on && (cyc % 7 == 3 || cyc % 13 > 9)) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result transaction, status %0d", $time, out_tdata[2:0]);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tdata[2:0] !== exp_r.status || out_tdata[34:3] !== exp_r.red ||
            out_tdata[66:35] !== exp_r.green || out_tdata[98:67] !== exp_r.blue ||
            out_tlast !== exp_r.line_end || out_tuser !== exp_r.frame_end) begin
          n_fail++;
          $display("%0t: mismatch expected st=%0d r=%h g=%h b=%h le=%b fe=%b", $time,
                   exp_r.status, exp_r.red, exp_r.green, exp_r.blue, exp_r.line_end,
                   exp_r.frame_end);
          $display("%0t:          actual   st=%0d r=%h g=%h b=%h le=%b fe=%b", $time,
                   out_tdata[2:0], out_tdata[34:3], out_tdata[66:35], out_tdata[98:67],
                   out_tlast, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    phase = PH_START;
    {plane, col, run_cnt, run_rep, lines, pix, drain, flat, err} = '0;
    reg_width = 13'd1;
    reg_height = 15'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_extreme_sizes();
    test_random_frames(2000);
    test_sticky_error();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Covered %0d pushes and %0d pulls, %0d pixel pulls, %0d run-length lines,",
             n_push, n_pull, n_pixels, n_lines_rle);
    $display("widths 1 to 140, heights 1 to 32767 and %0d sticky error case.", n_errs);
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
